// ===== rtl/core/i2c_eeprom_byte_engine_unit_defines.svh =====
// assertion macros shared by the checker of the eeprom byte engine
`ifndef I2C_EEPROM_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_EEPROM_BYTE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define IEB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ieb assertion failed");

// next-cycle implication under reset
`define IEB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ieb assertion failed");

`endif

// ===== rtl/core/ieb_pkg.sv =====
// types and constants of the eeprom byte engine
`default_nettype none

package ieb_pkg;

    localparam int ADDR_W_MAX = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/core/ieb_store.sv =====
// byte store with erase sweep after reset
`default_nettype none

module ieb_store
    import ieb_pkg::*;
#(
    parameter int MEM_BYTES = 32768
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_q,
    output logic          o_clr_busy
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [AW:0] r_clr_cnt;
    logic [7:0]  r_q;

    assign o_clr_busy = (r_clr_cnt != (AW + 1)'(MEM_BYTES));
    assign o_q        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (o_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_clr_busy) begin
            mem[r_clr_cnt[AW-1:0]] <= ERASED_BYTE;
        end else if (i_req.we) begin
            mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q <= mem[i_req.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ieb_reduce.sv =====
// remainder by a constant divisor through a reciprocal multiply; value, quotient and remainder are registered in turn
`default_nettype none

module ieb_reduce #(
    parameter int VW  = 16,
    parameter int DIV = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VW-1:0] i_value,
    output logic               o_done,
    output logic [$clog2(DIV)-1:0] o_result
);

    localparam int RW = $clog2(DIV);
    localparam int SH = VW + RW;
    localparam int QW = VW - RW + 1;
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [VW:0] RECIP_C = (VW + 1)'(RECIP);
    localparam logic [VW:0] DIV_C   = (VW + 1)'(DIV);

    logic [VW-1:0] r_v;
    logic [QW-1:0] r_q;
    logic [RW-1:0] r_r;
    logic          r_s1;
    logic          r_s2;
    logic          r_done;
    logic [2*VW:0] prod;
    logic [VW:0]   qd;
    logic [VW:0]   rem;

    // quotient from the scaled reciprocal, then value minus quotient times divisor
    always_comb begin
        prod = {{(VW + 1){1'b0}}, r_v} * {{VW{1'b0}}, RECIP_C};
        qd   = {{RW{1'b0}}, r_q} * DIV_C;
        rem  = {1'b0, r_v} - qd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
        end
        if (r_s1) begin
            r_q <= prod[SH +: QW];
        end
        if (r_s2) begin
            r_r <= rem[RW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

`default_nettype wire

// ===== rtl/core/i2c_eeprom_byte_engine_unit.sv =====
// top level of the eeprom byte engine: event decode, address state, store access
//
// usage
//   one bus event is a beat on i_cmd / i_data_byte, taken at a rising edge with
//   i_start high and o_busy low. every beat gives one result beat in the next cycle:
//   o_done is high for exactly that cycle with o_read_data and o_data_valid.
//   the receiver cannot hold results off, so results never stall.
//   read, data write, high address byte, repeated start and stop leave o_busy low;
//   the store is a single-port synchronous ram read or written once per beat.
//   the low address byte loads a new address, which is reduced modulo the memory
//   size and then modulo the page size, each by a reciprocal multiply: o_busy
//   stays high until both reductions are done, and only then is the next beat taken.
//   reset: synchronous, active low. afterwards o_busy stays high while the store
//   is swept to the erased value, one byte per cycle.
`default_nettype none

module i2c_eeprom_byte_engine_unit
    import ieb_pkg::*;
#(
    parameter int MEM_BYTES  = 32768,
    parameter int PAGE_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_byte,
    output logic            o_done,
    output logic [7:0]      o_read_data,
    output logic            o_data_valid
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);

    localparam logic [1:0] PH_ADDR_HI = 2'd0;
    localparam logic [1:0] PH_ADDR_LO = 2'd1;
    localparam logic [1:0] PH_DATA    = 2'd2;
    localparam logic [1:0] PH_READ    = 2'd3;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RED_A = 2'd1;
    localparam logic [1:0] S_RED_P = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_hi, n_hi;
    logic [AW-1:0] r_addr, n_addr;
    logic [PW-1:0] r_off, n_off;
    logic          r_done;
    logic          r_was_rd;

    logic          acc;
    logic          clr_busy;
    logic [7:0]    mem_q;
    t_mem_req      mem_req;

    logic          red_a_start;
    logic          red_a_done;
    logic [AW-1:0] red_a_res;
    logic          red_p_done;
    logic [PW-1:0] red_p_res;

    logic [AW:0]   lin_sum;
    logic          lin_wrap;
    logic          off_last;
    logic [AW-1:0] lin_addr;
    logic [PW-1:0] lin_off;
    logic [AW-1:0] pg_addr;
    logic [PW-1:0] pg_off;

    assign o_busy = clr_busy || (r_state != S_IDLE);
    assign acc    = i_start && !o_busy;

    // address stepping, linear for reads and inside the page for writes
    always_comb begin
        lin_sum  = {1'b0, r_addr} + 1'b1;
        lin_wrap = (lin_sum == (AW + 1)'(MEM_BYTES));
        off_last = (r_off == PW'(PAGE_BYTES - 1));
        lin_addr = lin_wrap ? '0 : lin_sum[AW-1:0];
        lin_off  = (lin_wrap || off_last) ? '0 : (r_off + 1'b1);
        if (off_last) begin
            pg_addr = r_addr - AW'(PAGE_BYTES - 1);
            pg_off  = '0;
        end else begin
            pg_addr = lin_addr;
            pg_off  = lin_off;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hi        = r_hi;
        n_addr      = r_addr;
        n_off       = r_off;
        red_a_start = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = ADDR_W_MAX'(r_addr);
        mem_req.wdata = i_data_byte;

        case (r_state)
            S_RED_A: begin
                if (red_a_done) begin
                    n_addr  = red_a_res;
                    n_state = S_RED_P;
                end
            end
            S_RED_P: begin
                if (red_p_done) begin
                    n_off   = red_p_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                if (acc) begin
                    case (i_cmd)
                        CMD_WRITE: begin
                            if (r_phase inside {PH_READ, PH_ADDR_HI}) begin
                                n_hi    = i_data_byte;
                                n_phase = PH_ADDR_LO;
                            end else if (r_phase == PH_ADDR_LO) begin
                                n_phase     = PH_DATA;
                                red_a_start = 1'b1;
                                n_state     = S_RED_A;
                            end else begin
                                mem_req.we = 1'b1;
                                n_addr     = pg_addr;
                                n_off      = pg_off;
                            end
                        end
                        CMD_READ: begin
                            mem_req.re = 1'b1;
                            n_addr     = lin_addr;
                            n_off      = lin_off;
                        end
                        CMD_START: begin
                            n_phase = PH_READ;
                        end
                        default: begin
                            n_phase = PH_ADDR_HI;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_ADDR_HI;
            r_hi     <= '0;
            r_addr   <= '0;
            r_off    <= '0;
            r_done   <= 1'b0;
            r_was_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_hi     <= n_hi;
            r_addr   <= n_addr;
            r_off    <= n_off;
            r_done   <= acc;
            r_was_rd <= acc && (i_cmd == CMD_READ);
        end
    end

    assign o_done       = r_done;
    assign o_data_valid = r_was_rd;
    assign o_read_data  = r_was_rd ? mem_q : 8'h00;

    ieb_store #(
        .MEM_BYTES(MEM_BYTES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_q        (mem_q),
        .o_clr_busy (clr_busy)
    );

    ieb_reduce #(
        .VW (ADDR_W_MAX),
        .DIV(MEM_BYTES)
    ) u_red_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (red_a_start),
        .i_value  ({r_hi, i_data_byte}),
        .o_done   (red_a_done),
        .o_result (red_a_res)
    );

    ieb_reduce #(
        .VW (AW),
        .DIV(PAGE_BYTES)
    ) u_red_page (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (red_a_done),
        .i_value  (red_a_res),
        .o_done   (red_p_done),
        .o_result (red_p_res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ieb_checker.sv =====
// port-level checker of the eeprom byte engine and its bind
`default_nettype none

`include "i2c_eeprom_byte_engine_unit_defines.svh"

module ieb_checker
    import ieb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic [1:0] i_cmd,
    input wire logic       o_done,
    input wire logic [7:0] o_read_data,
    input wire logic       o_data_valid
);

    logic acc;
    logic acc_rd;

    assign acc    = i_start && !o_busy;
    assign acc_rd = acc && (i_cmd == CMD_READ);

    // every beat gives exactly one result beat in the next cycle
    `IEB_ASSERT_NXT(a_done_after_beat, i_clk, i_rst_n, acc, o_done)
    `IEB_ASSERT_NXT(a_no_spurious_done, i_clk, i_rst_n, !acc, !o_done)
    // read data is flagged after every read, and is zero while not flagged
    `IEB_ASSERT_NXT(a_read_flagged, i_clk, i_rst_n, acc_rd, o_data_valid)
    `IEB_ASSERT_IMP(a_zero_when_not_read, i_clk, i_rst_n, !o_data_valid, o_read_data == 8'h00)

endmodule

bind i2c_eeprom_byte_engine_unit ieb_checker u_ieb_checker (.*);

`default_nettype wire
